// File: src/key_debounce_short_long_press_macros.svh
// Assertion macros shared by the key debouncer checker.
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define KDSLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define KDSLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/kdslp_pkg.sv
// Types and constants for the key debouncer.
package kdslp_pkg;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Key phase codes; unused codes behave as released.
	typedef enum logic [2:0] {
		PH_RELEASED    = 3'd0,
		PH_PRESS_DEB   = 3'd1,
		PH_SHORT       = 3'd2,
		PH_LONG        = 3'd3,
		PH_RELEASE_DEB = 3'd4
	} kdslp_phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ACTIVE_LEVEL   = 2'd0,
		CFG_DEBOUNCE_TICKS = 2'd1,
		CFG_LONG_TICKS     = 2'd2
	} kdslp_cfg_idx_t;

	typedef struct packed {
		kdslp_phase_t     phase;
		logic [CNT_W-1:0] count;
		logic             was_long;
	} kdslp_state_t;

	typedef struct packed {
		logic active_level;
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] long_ticks;
	} kdslp_cfg_t;

	typedef struct packed {
		logic long_press;
		logic short_press;
	} kdslp_event_t;

endpackage

// File: src/kdslp_step.sv
// Next-state and event logic of the key phase machine for one sample.
module kdslp_step (
	input  kdslp_pkg::kdslp_cfg_t   cfg,
	input  logic                    pin_level,
	input  kdslp_pkg::kdslp_state_t cur,
	output kdslp_pkg::kdslp_state_t nxt,
	output kdslp_pkg::kdslp_event_t ev
);
	import kdslp_pkg::*;

	logic             pressed;
	logic [CNT_W-1:0] count_inc;
	logic             deb_hit;
	logic             long_hit;

	assign pressed   = (pin_level == cfg.active_level);
	// saturating increment
	assign count_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + 1'b1;
	assign deb_hit   = (count_inc >= cfg.debounce_ticks);
	assign long_hit  = (count_inc >= cfg.long_ticks);

	// next phase
	always_comb begin
		nxt.phase = PH_RELEASED;
		case (cur.phase)
			PH_PRESS_DEB: begin
				if (pressed && deb_hit) nxt.phase = PH_SHORT;
				else if (pressed)       nxt.phase = PH_PRESS_DEB;
				else                    nxt.phase = PH_RELEASED;
			end
			PH_SHORT: begin
				if (!pressed)      nxt.phase = PH_RELEASE_DEB;
				else if (long_hit) nxt.phase = PH_LONG;
				else               nxt.phase = PH_SHORT;
			end
			PH_LONG: begin
				nxt.phase = pressed ? PH_LONG : PH_RELEASE_DEB;
			end
			PH_RELEASE_DEB: begin
				if (pressed)      nxt.phase = cur.was_long ? PH_LONG : PH_SHORT;
				else if (deb_hit) nxt.phase = PH_RELEASED;
				else              nxt.phase = PH_RELEASE_DEB;
			end
			default: begin
				nxt.phase = pressed ? PH_PRESS_DEB : PH_RELEASED;
			end
		endcase
	end

	// counter, long flag and events
	always_comb begin
		nxt.count    = cur.count;
		nxt.was_long = cur.was_long;
		ev           = '0;
		case (cur.phase)
			PH_PRESS_DEB: begin
				nxt.count = pressed ? count_inc : '0;
			end
			PH_SHORT: begin
				if (!pressed || long_hit) nxt.count = '0;
				else                      nxt.count = count_inc;
			end
			PH_LONG: begin
				if (!pressed) begin
					nxt.count    = '0;
					nxt.was_long = 1'b1;
				end
			end
			PH_RELEASE_DEB: begin
				if (pressed) begin
					nxt.count = '0;
				end else begin
					nxt.count = count_inc;
					if (deb_hit) begin
						nxt.was_long   = 1'b0;
						ev.long_press  = cur.was_long;
						ev.short_press = !cur.was_long;
					end
				end
			end
			default: begin
				if (pressed) nxt.count = '0;
			end
		endcase
	end

endmodule

// File: src/key_debounce_short_long_press.sv
// Top level of the key debouncer with short- and long-press events.
// One sampled key level enters per s_ transfer and exactly one result leaves per
// m_ transfer, bit 0 short_press and bit 1 long_press, at most one of them set. A
// sample can be taken every clock while s_tready is high: the phase machine, the
// 16-bit saturating sample counter and the long flag update on each sample
// transfer, and the result is registered in an output register with a one-entry
// skid behind it, so s_tready only drops when both are full. Configuration
// (active level, debounce ticks, long ticks) is written through the cfg_ channel,
// always ready; the user must write it only while the block is idle, which the
// block does not enforce. Writes to an index past the last register are dropped.
module key_debounce_short_long_press (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [0] pin_level, [7:1] zero
	// event stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [0] short_press, [1] long_press, [7:2] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kdslp_pkg::*;

	kdslp_cfg_t   cfg_q;
	kdslp_state_t state_q;
	kdslp_state_t state_nxt;
	kdslp_event_t ev;

	// output register and skid entry
	kdslp_event_t out_q;
	logic         out_valid_q;
	kdslp_event_t skid_q;
	logic         skid_valid_q;

	logic s_xfer;
	logic m_xfer;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign s_xfer    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_xfer    = out_valid_q && m_tready;
	assign m_tdata   = {6'd0, out_q.long_press, out_q.short_press};

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level   <= 1'b0;
			cfg_q.debounce_ticks <= 16'd2;
			cfg_q.long_ticks     <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_LEVEL:   cfg_q.active_level   <= cfg_data[0];
				CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data;
				CFG_LONG_TICKS:     cfg_q.long_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	kdslp_step u_step (
		.cfg       (cfg_q),
		.pin_level (s_tdata[0]),
		.cur       (state_q),
		.nxt       (state_nxt),
		.ev        (ev)
	);

	// machine state advances on every sample transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_RELEASED;
			state_q.count    <= '0;
			state_q.was_long <= 1'b0;
		end else if (s_xfer) begin
			state_q <= state_nxt;
		end
	end

	// result delivery: new result goes to the output register when it is free
	// or draining this cycle, otherwise parks in the skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_xfer) skid_valid_q <= 1'b0;
		end else if (s_xfer) begin
			if (!out_valid_q || m_xfer) out_valid_q <= 1'b1;
			else                        skid_valid_q <= 1'b1;
		end else if (m_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_xfer) out_q <= skid_q;
		end else if (s_xfer) begin
			if (!out_valid_q || m_xfer) out_q  <= ev;
			else                        skid_q <= ev;
		end
	end

endmodule

// File: src/kdslp_checker.sv
// Port-level checks for the key debouncer, bound to the top level.
`include "key_debounce_short_long_press_macros.svh"

module kdslp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// a released key yields one event kind at most
	`KDSLP_ASSERT_NOW(a_one_event, m_tvalid, !(m_tdata[0] && m_tdata[1]), "both events set")

	// padding bits of a result stay clear
	`KDSLP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:2] == 6'd0, "result padding not zero")

	// input only backs up when a result is held at the output
	`KDSLP_ASSERT_NOW(a_stall_has_out, !s_tready, m_tvalid, "input stalled with no result")

	// stalled result holds
	`KDSLP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost")

endmodule

bind key_debounce_short_long_press kdslp_checker u_kdslp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

// File: tb/tb_key_debounce_short_long_press.sv
// Self-checking testbench for the key debouncer with short- and long-press events.
`timescale 1ns / 1ps

module tb_key_debounce_short_long_press;

	import kdslp_pkg::*;

	// Index past the last register; writes to it must be dropped.
	localparam logic [1:0] CFG_NO_SUCH_REG = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] pin_level, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [0] short_press, [1] long_press, [7:2] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	key_debounce_short_long_press dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the key machine and its registers, reset values.
	kdslp_state_t key_st = '{phase: PH_RELEASED, count: '0, was_long: 1'b0};
	kdslp_cfg_t   key_cfg = '{active_level: 1'b0, debounce_ticks: 16'd2, long_ticks: 16'd100};

	kdslp_event_t expected_events[$];
	int unsigned  samples_sent = 0;   // sample transfers seen by the sender
	int unsigned  results_seen = 0;   // event transfers seen by the checker
	int unsigned  mismatches = 0;

	// Stimulus knobs shared with the receiver.
	bit idle_on = 1'b1;
	int hold_request = 0;   // receiver hold-off length in cycles, picked up once

	// Levels the stimulus is currently built around.
	logic press_lvl = 1'b0;
	int   deb_set = 2;
	int   long_set = 100;

	initial begin
		forever #5 clk = ~clk;
	end

	// Limit: far above the slowest legal run with the longest gaps and stalls.
	initial begin
		#(10_000_000);
		$display("key_debounce_short_long_press test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor: one sampled level in, one event out.
	// ------------------------------------------------------------------
	function automatic void count_bump();
		if (key_st.count != COUNT_MAX)
			key_st.count++;
	endfunction

	function automatic kdslp_event_t key_step(input logic pin);
		kdslp_event_t ev;
		logic         held;
		ev = '0;
		held = (pin == key_cfg.active_level);
		case (key_st.phase)
			PH_PRESS_DEB: begin
				if (held) begin
					count_bump();
					// count is carried into the short phase
					if (key_st.count >= key_cfg.debounce_ticks)
						key_st.phase = PH_SHORT;
				end else begin
					key_st.phase = PH_RELEASED;
					key_st.count = '0;
				end
			end
			PH_SHORT: begin
				if (held) begin
					count_bump();
					if (key_st.count >= key_cfg.long_ticks) begin
						key_st.phase = PH_LONG;
						key_st.count = '0;
					end
				end else begin
					key_st.phase = PH_RELEASE_DEB;
					key_st.count = '0;
				end
			end
			PH_LONG: begin
				if (!held) begin
					key_st.was_long = 1'b1;
					key_st.phase = PH_RELEASE_DEB;
					key_st.count = '0;
				end
			end
			PH_RELEASE_DEB: begin
				if (!held) begin
					count_bump();
					if (key_st.count >= key_cfg.debounce_ticks) begin
						key_st.phase = PH_RELEASED;
						if (key_st.was_long) begin
							key_st.was_long = 1'b0;
							ev.long_press = 1'b1;
						end else begin
							ev.short_press = 1'b1;
						end
					end
				end else begin
					// bounce: back to the press phase we came from
					key_st.phase = key_st.was_long ? PH_LONG : PH_SHORT;
					key_st.count = '0;
				end
			end
			default: begin
				key_st.phase = PH_RELEASED;
				if (held) begin
					key_st.phase = PH_PRESS_DEB;
					key_st.count = '0;
				end
			end
		endcase
		return ev;
	endfunction

	task automatic report_mismatch(input string what, input kdslp_event_t want,
			input kdslp_event_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s: expected short=%0b long=%0b, got short=%0b long=%0b",
				results_seen, what, want.short_press, want.long_press,
				got.short_press, got.long_press);
	endtask

	// ------------------------------------------------------------------
	// Monitor: register writes and samples feed the predictor, events are
	// checked against the oldest expectation. One process, so the order
	// of the three within one pass of the monitor is fixed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		kdslp_event_t got;
		kdslp_event_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ACTIVE_LEVEL:   key_cfg.active_level = cfg_data[0];
					CFG_DEBOUNCE_TICKS: key_cfg.debounce_ticks = cfg_data;
					CFG_LONG_TICKS:     key_cfg.long_ticks = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_events.push_back(key_step(s_tdata[0]));
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.short_press = m_tdata[0];
				got.long_press = m_tdata[1];
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected event", '0, got);
				end else begin
					want = expected_events.pop_front();
					if (got.short_press !== want.short_press)
						report_mismatch("short_press", want, got);
					else if (got.long_press !== want.long_press)
						report_mismatch("long_press", want, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a long hold-off on request.
	// ------------------------------------------------------------------
	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side. s_tvalid stays high between back-to-back samples and is
	// only lowered for a gap or at the end of a phase.
	// ------------------------------------------------------------------
	task automatic send_sample(input logic pin);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, pin};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic send_run(input logic pin, input int n);
		repeat (n) send_sample(pin);
	endtask

	// Stop offering and wait until every sample has its event.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_seen < samples_sent);
	endtask

	// cfg_valid is left high across back-to-back writes; end_writes drops it.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic lvl, input int deb, input int lng);
		write_reg(CFG_ACTIVE_LEVEL, {15'd0, lvl});
		write_reg(CFG_DEBOUNCE_TICKS, deb[15:0]);
		write_reg(CFG_LONG_TICKS, lng[15:0]);
		end_writes();
		press_lvl = lvl;
		deb_set = deb;
		long_set = lng;
	endtask

	// One press and release with optional bounce on both edges.
	task automatic key_gesture(input int hold_len);
		repeat ($urandom_range(0, 2)) begin
			send_sample(press_lvl);
			send_sample(!press_lvl);
		end
		send_run(press_lvl, hold_len);
		repeat ($urandom_range(0, 2)) begin
			send_sample(!press_lvl);
			send_sample(press_lvl);
		end
		send_run(!press_lvl, deb_set + $urandom_range(1, 3));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset registers: active low, debounce 2. Bounce while confirming the
	// press, bounce while confirming the release, then a short press event.
	task automatic test_reset_config();
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b0, 3);
		send_sample(1'b1);
		send_sample(1'b0);
		send_run(1'b1, 3);
		drain_events();
	endtask

	// Zero thresholds are met at once; active high; a write to an index past
	// the last register must change nothing.
	task automatic test_zero_thresholds();
		apply_setting(1'b1, 0, 0);
		write_reg(CFG_NO_SUCH_REG, 16'hFFFF);
		end_writes();
		send_run(1'b1, 3);     // press debounce, short, long
		send_sample(1'b0);     // release debounce with long flag
		send_sample(1'b1);     // bounce back to long
		send_run(1'b0, 2);     // long press event
		send_run(1'b1, 2);
		send_run(1'b0, 2);     // short press event
		drain_events();
	endtask

	// Receiver holds off while samples keep coming, so the output buffer
	// fills and s_tready drops; then the sender waits for a full drain.
	task automatic test_backpressure();
		apply_setting(1'b0, 1, 4);
		idle_on = 1'b0;
		hold_request = 60;
		repeat (4) key_gesture($urandom_range(1, 8));
		drain_events();
		idle_on = 1'b1;
		repeat (3) key_gesture($urandom_range(1, 8));
		drain_events();
	endtask

	// Mostly well-formed presses with random lengths and bounces, some noise.
	// The last setting runs without idling on either side.
	task automatic test_random_settings();
		int unsigned start;
		int          deb;
		int          lng;
		for (int k = 0; k < 6; k++) begin
			deb = (k == 0) ? 1 : $urandom_range(1, 6);
			lng = (k == 1) ? 1 : $urandom_range(1, 24);
			apply_setting(k[0], deb, lng);
			if (k == 5)
				idle_on = 1'b0;
			start = samples_sent;
			while (samples_sent - start < 100) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 5)) send_sample(1'($urandom_range(0, 1)));
				else if ($urandom_range(0, 1) == 0)
					key_gesture($urandom_range(0, deb + lng));
				else
					key_gesture(deb + lng + $urandom_range(1, 6));
			end
			drain_events();
		end
	endtask

	initial begin : main
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_zero_thresholds();
		test_backpressure();
		test_random_settings();
		// wait so that any stray event is caught
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("key_debounce_short_long_press test passed");
		end else begin
			$display("key_debounce_short_long_press test failed");
		end
		$finish;
	end

endmodule
